FILE: hdl/kmp_pkg.sv
// Shared constants, types and control structures of the KMP substring search block.
package kmp_pkg;

    localparam int PATTERN_MAX = 32;
    localparam int PAT_AW = $clog2(PATTERN_MAX);
    localparam int CNT_W = PAT_AW + 1;
    localparam int LEN_W = 6;
    localparam int TEXT_MAX = 65535;
    localparam int POS_W = $clog2(TEXT_MAX + 2);
    localparam int START_W = 16;
    localparam int BYTE_W = 8;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 64;
    localparam int PAT_REGS = (PATTERN_MAX * BYTE_W) / CFG_DATA_W;

    typedef logic [BYTE_W-1:0] byte_t;
    typedef logic [CNT_W-1:0] cnt_t;
    typedef logic [LEN_W-1:0] len_t;
    typedef logic [PAT_AW-1:0] pat_addr_t;
    typedef logic [POS_W-1:0] pos_t;
    typedef logic [START_W-1:0] start_t;
    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
    typedef logic [CFG_DATA_W-1:0] cfg_data_t;
    typedef logic [PATTERN_MAX-1:0][BYTE_W-1:0] pattern_t;

    localparam cfg_idx_t REG_PATTERN_LENGTH = 3'd0;
    localparam cfg_idx_t REG_START_POSITION = 3'd1;
    localparam cfg_idx_t REG_PATTERN_0_7 = 3'd2;
    localparam cfg_idx_t REG_PATTERN_8_15 = 3'd3;
    localparam cfg_idx_t REG_PATTERN_16_23 = 3'd4;
    localparam cfg_idx_t REG_PATTERN_24_31 = 3'd5;

    typedef struct packed {
        len_t length;
        start_t start;
        pattern_t pattern;
    } cfg_t;

    typedef struct packed {
        logic accept;
        logic latch;
        logic build_load;
        logic build_step;
        logic start;
        logic search_step;
        logic result_load;
        logic finish;
    } dp_cmd_t;

    typedef struct packed {
        logic new_text;
        logic build_done;
        logic build_match;
        logic compare_ok;
        logic search_stop;
        logic emit;
        logic out_free;
    } dp_status_t;

endpackage

FILE: hdl/kmp_if.sv
// Valid/ready channel interfaces for text items and result items.
interface kmp_text_if;
    import kmp_pkg::*;

    logic valid;
    logic ready;
    byte_t text_byte;
    logic text_end;

    modport source (output valid, output text_byte, output text_end, input ready);
    modport sink (input valid, input text_byte, input text_end, output ready);
endinterface

interface kmp_result_if;
    import kmp_pkg::*;

    logic valid;
    logic ready;
    start_t match_start;
    logic match_found;

    modport source (output valid, output match_start, output match_found, input ready);
    modport sink (input valid, input match_start, input match_found, output ready);
endinterface

FILE: hdl/kmp_substring_search.sv
// Top level of the KMP substring search block: configuration, sequencer and datapath.
//
//  Port       Direction  Payload                          Handshake
//  text       in         text_byte[7:0], text_end         valid/ready
//  result     out        match_start[15:0], match_found   valid/ready
//  cfg_*      in         cfg_index[2:0], cfg_data[63:0]   cfg_we, no wait
//
// The first item of a text latches the configuration and, before its own search, builds
// the failure table, repeating its step state on each fallback of the table loop.
// A compared item runs start, search and result states; a skipped one leaves out search.
// A new result waits in the sequencer for as long as the previous one is still held.
// A stalled result holds its register; the next item is taken while it waits.
// Reset is asynchronous and active low; it takes effect at once and needs no pass.
module kmp_substring_search (
    input  logic               clk,
    input  logic               rst_n,
    kmp_text_if.sink           text,
    kmp_result_if.source       result,
    input  logic               cfg_we,
    input  kmp_pkg::cfg_idx_t  cfg_index,
    input  kmp_pkg::cfg_data_t cfg_data
);
    import kmp_pkg::*;

    cfg_t cfg;
    dp_cmd_t cmd;
    dp_status_t status;

    kmp_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    kmp_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .text_valid (text.valid),
        .text_ready (text.ready),
        .status     (status),
        .cmd        (cmd)
    );

    kmp_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .text_byte   (text.text_byte),
        .text_end    (text.text_end),
        .cmd         (cmd),
        .status      (status),
        .out_valid   (result.valid),
        .out_ready   (result.ready),
        .match_start (result.match_start),
        .match_found (result.match_found)
    );

endmodule

FILE: hdl/kmp_cfg_regs.sv
// Configuration register file holding pattern length, start position and pattern bytes.
module kmp_cfg_regs (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  kmp_pkg::cfg_idx_t   cfg_index,
    input  kmp_pkg::cfg_data_t  cfg_data,
    output kmp_pkg::cfg_t       cfg
);
    import kmp_pkg::*;

    len_t length_reg;
    start_t start_reg;
    logic [PAT_REGS-1:0][CFG_DATA_W-1:0] pattern_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            length_reg <= len_t'(1);
            start_reg <= start_t'(1);
            pattern_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_PATTERN_LENGTH: length_reg <= cfg_data[LEN_W-1:0];
                REG_START_POSITION: start_reg <= cfg_data[START_W-1:0];
                REG_PATTERN_0_7: pattern_reg[0] <= cfg_data;
                REG_PATTERN_8_15: pattern_reg[1] <= cfg_data;
                REG_PATTERN_16_23: pattern_reg[2] <= cfg_data;
                REG_PATTERN_24_31: pattern_reg[3] <= cfg_data;
                default: ;
            endcase
        end
    end

    assign cfg.length = length_reg;
    assign cfg.start = start_reg;
    assign cfg.pattern = pattern_t'(pattern_reg);

endmodule

FILE: hdl/kmp_ctrl.sv
// Sequencer that steps the datapath through table build, search and result delivery.
module kmp_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 text_valid,
    output logic                 text_ready,
    input  kmp_pkg::dp_status_t  status,
    output kmp_pkg::dp_cmd_t     cmd
);
    import kmp_pkg::*;

    typedef enum logic [5:0] {
        ST_IDLE       = 6'b000001,
        ST_BUILD_LOAD = 6'b000010,
        ST_BUILD_STEP = 6'b000100,
        ST_START      = 6'b001000,
        ST_SEARCH     = 6'b010000,
        ST_RESULT     = 6'b100000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign text_ready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (text_valid)
                begin
                    cmd.accept = 1'b1;
                    cmd.latch = status.new_text;
                    state_next = status.new_text ? ST_BUILD_LOAD : ST_START;
                end
            end
            ST_BUILD_LOAD:
            begin
                if (status.build_done)
                begin
                    state_next = ST_START;
                end
                else
                begin
                    cmd.build_load = 1'b1;
                    state_next = ST_BUILD_STEP;
                end
            end
            ST_BUILD_STEP:
            begin
                cmd.build_step = 1'b1;
                if (status.build_match)
                begin
                    state_next = ST_BUILD_LOAD;
                end
            end
            ST_START:
            begin
                cmd.start = 1'b1;
                state_next = status.compare_ok ? ST_SEARCH : ST_RESULT;
            end
            ST_SEARCH:
            begin
                cmd.search_step = 1'b1;
                if (status.search_stop)
                begin
                    state_next = ST_RESULT;
                end
            end
            ST_RESULT:
            begin
                if (!status.emit)
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
                else if (status.out_free)
                begin
                    cmd.result_load = 1'b1;
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

FILE: hdl/kmp_dp.sv
// Datapath with latched pattern, failure table, match counters and the result register.
module kmp_dp (
    input  logic                 clk,
    input  logic                 rst_n,
    input  kmp_pkg::cfg_t        cfg,
    input  kmp_pkg::byte_t       text_byte,
    input  logic                 text_end,
    input  kmp_pkg::dp_cmd_t     cmd,
    output kmp_pkg::dp_status_t  status,
    output logic                 out_valid,
    input  logic                 out_ready,
    output kmp_pkg::start_t      match_start,
    output logic                 match_found
);
    import kmp_pkg::*;

    byte_t pat_mem [PATTERN_MAX];
    cnt_t fail_mem [PATTERN_MAX];

    pos_t idx_reg;
    cnt_t matched_reg;
    logic given_reg;
    logic pending_reg;
    logic out_valid_reg;

    cnt_t len_reg;
    start_t start_reg;
    cnt_t i_reg;
    cnt_t j_reg;
    byte_t pi_reg;
    byte_t byte_reg;
    logic last_reg;
    start_t match_pos_reg;
    start_t match_start_reg;
    logic match_found_reg;

    cnt_t len_norm;
    start_t start_norm;
    pat_addr_t rd_addr;
    pat_addr_t j_addr;
    byte_t pat_rd;
    cnt_t fail_rd;
    logic out_free;

    always_comb
    begin
        if (cfg.length == len_t'(0))
        begin
            len_norm = cnt_t'(1);
        end
        else if (cfg.length > len_t'(PATTERN_MAX))
        begin
            len_norm = cnt_t'(PATTERN_MAX);
        end
        else
        begin
            len_norm = cnt_t'(cfg.length);
        end
    end

    assign start_norm = (cfg.start == start_t'(0)) ? start_t'(1) : cfg.start;

    assign j_addr = pat_addr_t'(j_reg - cnt_t'(1));
    assign rd_addr = cmd.build_load ? pat_addr_t'(i_reg - cnt_t'(1)) : j_addr;
    assign pat_rd = pat_mem[rd_addr];
    assign fail_rd = fail_mem[j_addr];
    assign out_free = !out_valid_reg || out_ready;

    assign status.new_text = (idx_reg == pos_t'(0));
    assign status.build_done = (i_reg >= len_reg);
    assign status.build_match = (j_reg == cnt_t'(0)) || (pi_reg == pat_rd);
    assign status.compare_ok = !given_reg && (idx_reg >= pos_t'(start_reg))
                               && (idx_reg <= pos_t'(TEXT_MAX));
    assign status.search_stop = (j_reg == cnt_t'(0)) || (byte_reg == pat_rd);
    assign status.emit = pending_reg || (last_reg && !given_reg);
    assign status.out_free = out_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg <= '0;
            matched_reg <= '0;
            given_reg <= 1'b0;
            pending_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.accept && !idx_reg[POS_W-1])
            begin
                idx_reg <= idx_reg + pos_t'(1);
            end
            if (cmd.latch)
            begin
                matched_reg <= '0;
                given_reg <= 1'b0;
            end
            if (cmd.start)
            begin
                pending_reg <= 1'b0;
            end
            if (cmd.search_step && status.search_stop)
            begin
                if (j_reg >= len_reg)
                begin
                    pending_reg <= 1'b1;
                    given_reg <= 1'b1;
                    matched_reg <= '0;
                end
                else
                begin
                    matched_reg <= j_reg;
                end
            end
            if (cmd.result_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cmd.finish && last_reg)
            begin
                idx_reg <= '0;
                matched_reg <= '0;
                given_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            byte_reg <= text_byte;
            last_reg <= text_end;
        end
        if (cmd.latch)
        begin
            len_reg <= len_norm;
            start_reg <= start_norm;
            i_reg <= cnt_t'(1);
            j_reg <= '0;
            for (int k = 0; k < PATTERN_MAX; k++)
            begin
                pat_mem[k] <= cfg.pattern[k];
            end
            fail_mem[0] <= '0;
        end
        if (cmd.build_load)
        begin
            pi_reg <= pat_rd;
        end
        if (cmd.build_step)
        begin
            if (status.build_match)
            begin
                i_reg <= i_reg + cnt_t'(1);
                j_reg <= j_reg + cnt_t'(1);
                fail_mem[i_reg[PAT_AW-1:0]] <= j_reg + cnt_t'(1);
            end
            else
            begin
                j_reg <= fail_rd;
            end
        end
        if (cmd.start)
        begin
            j_reg <= matched_reg + cnt_t'(1);
        end
        if (cmd.search_step)
        begin
            if (status.search_stop)
            begin
                match_pos_reg <= idx_reg[START_W-1:0] + start_t'(1) - start_t'(len_reg);
            end
            else
            begin
                j_reg <= fail_rd;
            end
        end
        if (cmd.result_load)
        begin
            match_start_reg <= pending_reg ? match_pos_reg : start_t'(0);
            match_found_reg <= pending_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign match_start = match_start_reg;
    assign match_found = match_found_reg;

endmodule
